[rtl/core/flvtsa_pkg.sv]
// Package for the FLV tag stream analyzer: parse phases, status codes,
// tag type and audio format codes, signature and rate tables, record types.
// No dependencies.
package flvtsa_pkg;

  typedef enum logic [3:0] {
    PH_SIG    = 4'd0,
    PH_FLAGS  = 4'd1,
    PH_HSIZE  = 4'd2,
    PH_EXTRA  = 4'd3,
    PH_PREV0  = 4'd4,
    PH_TTYPE  = 4'd5,
    PH_TLEN   = 4'd6,
    PH_TSTAMP = 4'd7,
    PH_TEXT   = 4'd8,
    PH_TSID   = 4'd9,
    PH_BODY   = 4'd10,
    PH_POST   = 4'd11,
    PH_HALT   = 4'd12
  } phase_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FIXED   = 3'd1;
  localparam logic [2:0] ST_DISCONT = 3'd2;
  localparam logic [2:0] ST_BAD_HDR = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  localparam logic [7:0] TYPE_AUDIO = 8'd8;
  localparam logic [7:0] TYPE_VIDEO = 8'd9;
  localparam logic [7:0] TYPE_META  = 8'd18;

  localparam logic [3:0] AFMT_FIXED_16K = 4'd4;
  localparam logic [3:0] AFMT_FIXED_8K  = 4'd5;
  localparam logic [3:0] VFRAME_KEY     = 4'd1;

  localparam logic [15:0] RATE_5K5  = 16'd5500;
  localparam logic [15:0] RATE_11K  = 16'd11000;
  localparam logic [15:0] RATE_22K  = 16'd22000;
  localparam logic [15:0] RATE_44K1 = 16'd44100;
  localparam logic [15:0] RATE_16K  = 16'd16000;
  localparam logic [15:0] RATE_8K   = 16'd8000;

  localparam logic [31:0] HDR_MIN_SIZE = 32'd9;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0: v = 8'h46;
      2'd1: v = 8'h4C;
      2'd2: v = 8'h56;
      2'd3: v = 8'h01;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rate_of_code(input logic [1:0] code);
    logic [15:0] v;
    unique case (code)
      2'd0: v = RATE_5K5;
      2'd1: v = RATE_11K;
      2'd2: v = RATE_22K;
      2'd3: v = RATE_44K1;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [3:0]  codec;
    logic        key;
    logic [15:0] rate;
    logic        s16;
    logic        stereo;
    logic        count_video;
    logic        count_audio;
  } decode_t;

  // Packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] keyframe_total;
    logic [31:0] audio_bytes_total;
    logic [31:0] video_bytes_total;
    logic        is_stereo;
    logic        sample_is_16bit;
    logic [15:0] sample_rate_hz;
    logic        is_keyframe;
    logic [3:0]  codec_or_format;
    logic [31:0] timestamp_ms;
    logic [23:0] body_len;
    logic [7:0]  tag_kind;
    logic [2:0]  status;
  } record_t;

endpackage

[rtl/core/flv_tag_stream_analyzer_core.sv]
// FLV tag stream analyzer top level: byte parser, timestamp repair, totals
// and the record output register. Depends on flvtsa_pkg, flvtsa_body_decode.
//
// Takes one FLV file byte per cycle on the in_ stream (in_tlast marks the
// last byte of a file) and emits one record per finished tag, per bad or
// short header, or per tag cut off by the end of the file. A byte is taken
// in every cycle in which the output register is empty or being drained, so
// the sustained rate is one byte per clock; a record appears on out_ the
// cycle after the byte that completes it. All state, totals included,
// returns to reset after each byte marked with in_tlast. Running totals are
// TOTAL_WIDTH bits wide, saturate, and are reported capped to 32 bits.
module flv_tag_stream_analyzer_core #(
  parameter int TOTAL_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], tag_kind[10:3], body_len[34:11], timestamp_ms[66:35],
  // codec_or_format[70:67], is_keyframe[71], sample_rate_hz[87:72],
  // sample_is_16bit[88], is_stereo[89], video_bytes_total[121:90],
  // audio_bytes_total[153:122], keyframe_total[185:154], zeros above
  output logic [191:0] out_tdata
);

  localparam int TW = TOTAL_WIDTH;
  localparam int SW = ((TW > 24) ? TW : 24) + 1;
  localparam int CW = (TW > 32) ? TW : 32;
  localparam logic [SW-1:0] CNT_MAX_EXT = {{(SW-TW){1'b0}}, {TW{1'b1}}};

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] cur,
                                            input logic [SW-1:0] add);
    logic [SW-1:0] sum;
    sum = SW'(cur) + add;
    return (sum > CNT_MAX_EXT) ? {TW{1'b1}} : sum[TW-1:0];
  endfunction

  function automatic logic [31:0] cap32(input logic [TW-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    return (ext > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

  flvtsa_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]   fc_r, fc_nxt, fc_inc;
  logic [31:0]   hes_r, hes_nxt, hes_full, hes_extra;
  logic [7:0]    type_r, type_nxt;
  logic [23:0]   len_r, len_nxt;
  logic [31:0]   stamp_r, stamp_nxt;
  logic [7:0]    fb_r, fb_nxt;
  logic [31:0]   lvs_r, lvs_nxt;
  logic [TW-1:0] vcnt_r, vcnt_nxt, acnt_r, acnt_nxt, kcnt_r, kcnt_nxt;

  logic          in_accept, eos;
  logic [7:0]    b;
  logic          bad_sig, finish;
  logic [31:0]   ts_fix;
  logic [2:0]    fix_status;
  flvtsa_pkg::decode_t dec;

  logic          rec_valid;
  flvtsa_pkg::record_t rec, out_rec_r;
  logic          out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign eos       = in_tlast;
  assign fc_inc    = fc_r + 32'd1;
  assign hes_full  = {hes_r[23:0], b};
  assign hes_extra = (hes_full < flvtsa_pkg::HDR_MIN_SIZE) ? 32'd0
                                                           : hes_full - flvtsa_pkg::HDR_MIN_SIZE;

  flvtsa_body_decode u_decode (
    .tag_kind   (type_r),
    .has_body   (len_r != 24'd0),
    .first_byte (fb_r),
    .dec        (dec)
  );

  // Wrapped-timestamp repair against the last video timestamp.
  always_comb begin
    ts_fix     = stamp_r;
    fix_status = flvtsa_pkg::ST_OK;
    if (stamp_r < lvs_r) begin
      if (stamp_r[31:24] == 8'd0 && lvs_r[31:20] != 12'd0) begin
        ts_fix     = {lvs_r[31:24] + {7'd0, (stamp_r[23:0] < lvs_r[23:0])},
                      stamp_r[23:0]};
        fix_status = flvtsa_pkg::ST_FIXED;
      end else if (type_r == flvtsa_pkg::TYPE_VIDEO ||
                   type_r == flvtsa_pkg::TYPE_META) begin
        fix_status = flvtsa_pkg::ST_DISCONT;
      end
    end
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    hes_nxt   = hes_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    stamp_nxt = stamp_r;
    fb_nxt    = fb_r;
    lvs_nxt   = lvs_r;
    vcnt_nxt  = vcnt_r;
    acnt_nxt  = acnt_r;
    kcnt_nxt  = kcnt_r;
    bad_sig   = 1'b0;
    finish    = 1'b0;
    unique case (phase_r)
      flvtsa_pkg::PH_SIG: begin
        if (b != flvtsa_pkg::sig_byte(fc_r[1:0])) begin
          bad_sig   = 1'b1;
          phase_nxt = flvtsa_pkg::PH_HALT;
        end else if (fc_r[1:0] == 2'd3) begin
          fc_nxt    = '0;
          phase_nxt = flvtsa_pkg::PH_FLAGS;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_FLAGS: begin
        hes_nxt   = '0;
        fc_nxt    = '0;
        phase_nxt = flvtsa_pkg::PH_HSIZE;
      end
      flvtsa_pkg::PH_HSIZE: begin
        if (fc_r[1:0] == 2'd3) begin
          hes_nxt   = hes_extra;
          fc_nxt    = '0;
          phase_nxt = (hes_extra != 32'd0) ? flvtsa_pkg::PH_EXTRA : flvtsa_pkg::PH_PREV0;
        end else begin
          hes_nxt = hes_full;
          fc_nxt  = fc_inc;
        end
      end
      flvtsa_pkg::PH_EXTRA: begin
        if (fc_inc == hes_r) begin
          fc_nxt    = '0;
          phase_nxt = flvtsa_pkg::PH_PREV0;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_PREV0: begin
        if (fc_r[1:0] == 2'd3) begin
          fc_nxt    = '0;
          phase_nxt = flvtsa_pkg::PH_TTYPE;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_TTYPE: begin
        type_nxt  = b;
        len_nxt   = '0;
        stamp_nxt = '0;
        fb_nxt    = '0;
        fc_nxt    = '0;
        phase_nxt = flvtsa_pkg::PH_TLEN;
      end
      flvtsa_pkg::PH_TLEN: begin
        len_nxt = {len_r[15:0], b};
        if (fc_r[1:0] == 2'd2) begin
          fc_nxt    = '0;
          phase_nxt = flvtsa_pkg::PH_TSTAMP;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_TSTAMP: begin
        stamp_nxt = {8'd0, stamp_r[15:0], b};
        if (fc_r[1:0] == 2'd2) begin
          fc_nxt    = '0;
          phase_nxt = flvtsa_pkg::PH_TEXT;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_TEXT: begin
        stamp_nxt = {b, stamp_r[23:0]};
        fc_nxt    = '0;
        phase_nxt = flvtsa_pkg::PH_TSID;
      end
      flvtsa_pkg::PH_TSID: begin
        if (fc_r[1:0] == 2'd2) begin
          fc_nxt    = '0;
          phase_nxt = (len_r != 24'd0) ? flvtsa_pkg::PH_BODY : flvtsa_pkg::PH_POST;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_BODY: begin
        if (fc_r == 32'd0) begin
          fb_nxt = b;
        end
        if (fc_inc == {8'd0, len_r}) begin
          fc_nxt    = '0;
          phase_nxt = flvtsa_pkg::PH_POST;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_POST: begin
        if (fc_r[1:0] == 2'd3) begin
          finish    = 1'b1;
          fc_nxt    = '0;
          phase_nxt = flvtsa_pkg::PH_TTYPE;
          if (type_r == flvtsa_pkg::TYPE_VIDEO && ts_fix > lvs_r) begin
            lvs_nxt = ts_fix;
          end
          if (dec.count_video) begin
            vcnt_nxt = sat_add(vcnt_r, SW'(len_r) - SW'(1));
          end
          if (dec.key) begin
            kcnt_nxt = sat_add(kcnt_r, SW'(1));
          end
          if (dec.count_audio) begin
            acnt_nxt = sat_add(acnt_r, SW'(len_r));
          end
        end else begin
          fc_nxt = fc_inc;
        end
      end
      flvtsa_pkg::PH_HALT: begin
        phase_nxt = flvtsa_pkg::PH_HALT;
      end
      default: begin
        phase_nxt = flvtsa_pkg::PH_HALT;
      end
    endcase
  end

  // Record for this item
  always_comb begin
    rec                   = '0;
    rec_valid             = 1'b0;
    rec.video_bytes_total = cap32(vcnt_nxt);
    rec.audio_bytes_total = cap32(acnt_nxt);
    rec.keyframe_total    = cap32(kcnt_nxt);
    if (bad_sig) begin
      rec_valid  = 1'b1;
      rec.status = flvtsa_pkg::ST_BAD_HDR;
    end else if (finish) begin
      rec_valid           = 1'b1;
      rec.status          = fix_status;
      rec.tag_kind        = type_r;
      rec.body_len        = len_r;
      rec.timestamp_ms    = ts_fix;
      rec.codec_or_format = dec.codec;
      rec.is_keyframe     = dec.key;
      rec.sample_rate_hz  = dec.rate;
      rec.sample_is_16bit = dec.s16;
      rec.is_stereo       = dec.stereo;
    end else if (eos) begin
      if (phase_nxt <= flvtsa_pkg::PH_PREV0) begin
        rec_valid  = 1'b1;
        rec.status = flvtsa_pkg::ST_BAD_HDR;
      end else if (phase_nxt >= flvtsa_pkg::PH_TLEN && phase_nxt <= flvtsa_pkg::PH_POST) begin
        rec_valid        = 1'b1;
        rec.status       = flvtsa_pkg::ST_TRUNC;
        rec.tag_kind     = type_nxt;
        rec.body_len     = len_nxt;
        rec.timestamp_ms = stamp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && eos)) begin
      phase_r <= flvtsa_pkg::PH_SIG;
      fc_r    <= '0;
      hes_r   <= '0;
      type_r  <= '0;
      len_r   <= '0;
      stamp_r <= '0;
      fb_r    <= '0;
      lvs_r   <= '0;
      vcnt_r  <= '0;
      acnt_r  <= '0;
      kcnt_r  <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      hes_r   <= hes_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      stamp_r <= stamp_nxt;
      fb_r    <= fb_nxt;
      lvs_r   <= lvs_nxt;
      vcnt_r  <= vcnt_nxt;
      acnt_r  <= acnt_nxt;
      kcnt_r  <= kcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= rec_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && rec_valid) begin
      out_rec_r <= rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rec_r;

endmodule

[rtl/core/flvtsa_body_decode.sv]
// First-body-byte decoder: video codec and keyframe flag, or audio format,
// rate, sample size and channel flag. Depends on flvtsa_pkg.
module flvtsa_body_decode (
  input  logic [7:0]           tag_kind,
  input  logic                 has_body,
  input  logic [7:0]           first_byte,
  output flvtsa_pkg::decode_t  dec
);

  always_comb begin
    dec = '0;
    if (tag_kind == flvtsa_pkg::TYPE_VIDEO && has_body) begin
      dec.codec       = first_byte[3:0];
      dec.key         = (first_byte[7:4] == flvtsa_pkg::VFRAME_KEY);
      dec.count_video = 1'b1;
    end else if (tag_kind == flvtsa_pkg::TYPE_AUDIO && has_body) begin
      dec.codec       = first_byte[7:4];
      dec.rate        = flvtsa_pkg::rate_of_code(first_byte[3:2]);
      dec.s16         = first_byte[1];
      dec.stereo      = first_byte[0];
      dec.count_audio = 1'b1;
      if (first_byte[7:4] == flvtsa_pkg::AFMT_FIXED_16K) begin
        dec.rate   = flvtsa_pkg::RATE_16K;
        dec.s16    = 1'b0;
        dec.stereo = 1'b0;
      end else if (first_byte[7:4] == flvtsa_pkg::AFMT_FIXED_8K) begin
        dec.rate   = flvtsa_pkg::RATE_8K;
        dec.s16    = 1'b0;
        dec.stereo = 1'b0;
      end
    end
  end

endmodule

[tb/flv_tag_stream_analyzer_core_tb.sv]
// Testbench for flv_tag_stream_analyzer_core: feeds FLV byte streams, predicts
// each tag record and compares every field of every emitted record.
// Depends on flvtsa_pkg and the analyzer RTL; stands alone otherwise.
module flv_tag_stream_analyzer_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LIVE_BYTES = 1950;
  localparam int TAIL_CYCLES = 20;
  localparam int BODY_CAP = 64;
  localparam logic [0:3][7:0] FLV_SIG = {8'h46, 8'h4C, 8'h56, 8'h01};
  localparam logic [0:3][15:0] AUDIO_RATES = {flvtsa_pkg::RATE_5K5, flvtsa_pkg::RATE_11K,
                                               flvtsa_pkg::RATE_22K, flvtsa_pkg::RATE_44K1};

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         drain;
  } byte_item_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;

  flv_tag_stream_analyzer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // parser shadow state
  flvtsa_pkg::phase_t ph;
  logic [31:0] fcnt, hdr_extra, cur_ts, last_vts;
  logic [31:0] vid_total, aud_total, key_total;
  logic [7:0]  cur_type, first_b;
  logic [23:0] cur_len;

  flvtsa_pkg::record_t tag_records[$];
  byte_item_t pend_q[$];
  logic [7:0] file_bytes[$];
  int records_pred = 0;
  int records_rx = 0;
  int errors = 0;
  int cycles = 0;
  int live_bytes = 0;
  int files_sent = 0;
  int status_seen[8];

  task automatic clear_parser();
    ph = flvtsa_pkg::PH_SIG;
    fcnt = '0;
    hdr_extra = '0;
    cur_type = '0;
    cur_len = '0;
    cur_ts = '0;
    first_b = '0;
    last_vts = '0;
    vid_total = '0;
    aud_total = '0;
    key_total = '0;
  endtask

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] inc);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, inc};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic flvtsa_pkg::record_t make_rec(input logic [2:0] st,
                                                   input logic [7:0] ty,
                                                   input logic [23:0] len,
                                                   input logic [31:0] ts,
                                                   input logic [3:0] codec,
                                                   input logic key,
                                                   input logic [15:0] rate,
                                                   input logic s16,
                                                   input logic stereo);
    flvtsa_pkg::record_t r;
    r = '0;
    r.status = st;
    r.tag_kind = ty;
    r.body_len = len;
    r.timestamp_ms = ts;
    r.codec_or_format = codec;
    r.is_keyframe = key;
    r.sample_rate_hz = rate;
    r.sample_is_16bit = s16;
    r.is_stereo = stereo;
    r.video_bytes_total = vid_total;
    r.audio_bytes_total = aud_total;
    r.keyframe_total = key_total;
    return r;
  endfunction

  function automatic string rec_text(input flvtsa_pkg::record_t r);
    return $sformatf({"st=%0d type=%02h len=%06h ts=%08h codec=%0h key=%0b rate=%0d ",
                      "s16=%0b stereo=%0b vid=%0d aud=%0d keys=%0d pad=%0h"},
                     r.status, r.tag_kind, r.body_len, r.timestamp_ms,
                     r.codec_or_format, r.is_keyframe, r.sample_rate_hz,
                     r.sample_is_16bit, r.is_stereo, r.video_bytes_total,
                     r.audio_bytes_total, r.keyframe_total, r.pad);
  endfunction

  // Advances the shadow parser by one accepted byte, queues any record it yields.
  task automatic parse_byte(input logic [7:0] b, input logic eos);
    flvtsa_pkg::record_t rec;
    logic        hit;
    logic [2:0]  st;
    logic [31:0] ts, nt;
    logic [3:0]  codec;
    logic        key, s16, stereo;
    logic [15:0] rate;
    hit = 1'b0;
    rec = '0;
    case (ph)
      flvtsa_pkg::PH_SIG: begin
        if (b !== FLV_SIG[fcnt[1:0]]) begin
          rec = make_rec(flvtsa_pkg::ST_BAD_HDR, 8'h00, 24'h0, 32'h0, 4'h0, 1'b0,
                         16'h0, 1'b0, 1'b0);
          hit = 1'b1;
          ph = flvtsa_pkg::PH_HALT;
        end else begin
          fcnt = fcnt + 1;
          if (fcnt >= 4) begin
            fcnt = 0;
            ph = flvtsa_pkg::PH_FLAGS;
          end
        end
      end
      flvtsa_pkg::PH_FLAGS: begin
        hdr_extra = 0;
        fcnt = 0;
        ph = flvtsa_pkg::PH_HSIZE;
      end
      flvtsa_pkg::PH_HSIZE: begin
        hdr_extra = {hdr_extra[23:0], b};
        fcnt = fcnt + 1;
        if (fcnt >= 4) begin
          hdr_extra = (hdr_extra < flvtsa_pkg::HDR_MIN_SIZE) ? 32'h0
                                                             : hdr_extra - flvtsa_pkg::HDR_MIN_SIZE;
          fcnt = 0;
          ph = (hdr_extra != 0) ? flvtsa_pkg::PH_EXTRA : flvtsa_pkg::PH_PREV0;
        end
      end
      flvtsa_pkg::PH_EXTRA: begin
        fcnt = fcnt + 1;
        if (fcnt >= hdr_extra) begin
          fcnt = 0;
          ph = flvtsa_pkg::PH_PREV0;
        end
      end
      flvtsa_pkg::PH_PREV0: begin
        fcnt = fcnt + 1;
        if (fcnt >= 4) begin
          fcnt = 0;
          ph = flvtsa_pkg::PH_TTYPE;
        end
      end
      flvtsa_pkg::PH_TTYPE: begin
        cur_type = b;
        cur_len = 0;
        cur_ts = 0;
        first_b = 0;
        fcnt = 0;
        ph = flvtsa_pkg::PH_TLEN;
      end
      flvtsa_pkg::PH_TLEN: begin
        cur_len = {cur_len[15:0], b};
        fcnt = fcnt + 1;
        if (fcnt >= 3) begin
          fcnt = 0;
          ph = flvtsa_pkg::PH_TSTAMP;
        end
      end
      flvtsa_pkg::PH_TSTAMP: begin
        cur_ts = {8'h00, cur_ts[15:0], b};
        fcnt = fcnt + 1;
        if (fcnt >= 3) begin
          fcnt = 0;
          ph = flvtsa_pkg::PH_TEXT;
        end
      end
      flvtsa_pkg::PH_TEXT: begin
        cur_ts[31:24] = b;
        fcnt = 0;
        ph = flvtsa_pkg::PH_TSID;
      end
      flvtsa_pkg::PH_TSID: begin
        fcnt = fcnt + 1;
        if (fcnt >= 3) begin
          fcnt = 0;
          ph = (cur_len != 0) ? flvtsa_pkg::PH_BODY : flvtsa_pkg::PH_POST;
        end
      end
      flvtsa_pkg::PH_BODY: begin
        if (fcnt == 0) first_b = b;
        fcnt = fcnt + 1;
        if (fcnt >= {8'h00, cur_len}) begin
          fcnt = 0;
          ph = flvtsa_pkg::PH_POST;
        end
      end
      flvtsa_pkg::PH_POST: begin
        fcnt = fcnt + 1;
        if (fcnt >= 4) begin
          st = flvtsa_pkg::ST_OK;
          ts = cur_ts;
          codec = 0;
          key = 0;
          rate = 0;
          s16 = 0;
          stereo = 0;
          // wrapped stamp: borrow the upper byte of the last video stamp
          if (ts < last_vts) begin
            if (ts[31:24] == 8'h00 && (last_vts & 32'hFFF0_0000) != 0) begin
              nt = ts + {last_vts[31:24], 24'h0};
              if (nt < last_vts) nt = nt + 32'h0100_0000;
              ts = nt;
              st = flvtsa_pkg::ST_FIXED;
            end else if (cur_type == flvtsa_pkg::TYPE_VIDEO ||
                         cur_type == flvtsa_pkg::TYPE_META) begin
              st = flvtsa_pkg::ST_DISCONT;
            end
          end
          if (cur_type == flvtsa_pkg::TYPE_VIDEO && ts > last_vts) last_vts = ts;
          if (cur_type == flvtsa_pkg::TYPE_VIDEO && cur_len != 0) begin
            codec = first_b[3:0];
            key = (first_b[7:4] == flvtsa_pkg::VFRAME_KEY);
            if (key) key_total = sat_add32(key_total, 32'd1);
            vid_total = sat_add32(vid_total, {8'h00, cur_len} - 32'd1);
          end else if (cur_type == flvtsa_pkg::TYPE_AUDIO && cur_len != 0) begin
            codec = first_b[7:4];
            rate = AUDIO_RATES[first_b[3:2]];
            s16 = first_b[1];
            stereo = first_b[0];
            if (codec == flvtsa_pkg::AFMT_FIXED_16K) begin
              rate = flvtsa_pkg::RATE_16K;
              s16 = 0;
              stereo = 0;
            end else if (codec == flvtsa_pkg::AFMT_FIXED_8K) begin
              rate = flvtsa_pkg::RATE_8K;
              s16 = 0;
              stereo = 0;
            end
            aud_total = sat_add32(aud_total, {8'h00, cur_len});
          end
          rec = make_rec(st, cur_type, cur_len, ts, codec, key, rate, s16, stereo);
          hit = 1'b1;
          fcnt = 0;
          ph = flvtsa_pkg::PH_TTYPE;
        end
      end
      default: ph = flvtsa_pkg::PH_HALT;
    endcase

    if (eos) begin
      if (!hit) begin
        if (ph <= flvtsa_pkg::PH_PREV0) begin
          rec = make_rec(flvtsa_pkg::ST_BAD_HDR, 8'h00, 24'h0, 32'h0, 4'h0, 1'b0,
                         16'h0, 1'b0, 1'b0);
          hit = 1'b1;
        end else if (ph >= flvtsa_pkg::PH_TLEN && ph <= flvtsa_pkg::PH_POST) begin
          rec = make_rec(flvtsa_pkg::ST_TRUNC, cur_type, cur_len, cur_ts, 4'h0, 1'b0,
                         16'h0, 1'b0, 1'b0);
          hit = 1'b1;
        end
      end
      clear_parser();
    end
    if (hit) begin
      tag_records.insert(tag_records.size(), rec);
      records_pred++;
    end
  endtask

  task automatic put_byte(input logic [7:0] v);
    file_bytes.insert(file_bytes.size(), v);
  endtask

  // very long headers and bodies are cut short; such files always end early
  task automatic add_header(input logic [31:0] hsize);
    int i;
    for (i = 0; i < 4; i++) put_byte(FLV_SIG[i]);
    put_byte(8'($urandom));
    for (i = 3; i >= 0; i--) put_byte(hsize[8*i +: 8]);
    for (i = 9; i < hsize && i < 9 + BODY_CAP; i++) put_byte(8'($urandom));
    for (i = 0; i < 4; i++) put_byte(8'($urandom));
  endtask

  task automatic add_tag(input logic [7:0] ty, input logic [23:0] len,
                         input logic [31:0] ts, input logic [7:0] fb);
    int i;
    put_byte(ty);
    put_byte(len[23:16]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    put_byte(ts[23:16]);
    put_byte(ts[15:8]);
    put_byte(ts[7:0]);
    put_byte(ts[31:24]);
    for (i = 0; i < 3; i++) put_byte(8'($urandom));
    for (i = 0; i < len && i < BODY_CAP; i++)
      put_byte(i == 0 ? fb : 8'($urandom));
    for (i = 0; i < 4; i++) put_byte(8'($urandom));
  endtask

  task automatic emit_file(input int cut, input bit drain);
    byte_item_t it;
    int i;
    for (i = 0; i <= cut; i++) begin
      it.b = file_bytes[i];
      it.last = (i == cut);
      it.drain = drain && (i == 0);
      pend_q.insert(pend_q.size(), it);
    end
    files_sent++;
  endtask

  // byte driver
  int gap_left = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin : drive_bytes
    logic nv;
    byte_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_parser();
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0 &&
                     (!pend_q[0].drain || records_rx == records_pred)) begin
          it = pend_q.pop_front();
          in_tdata <= it.b;
          in_tlast <= it.last;
          nv = 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
          gap_left = send_burst ? 0 : $urandom_range(0, 10);
        end
      end
      in_tvalid <= nv;
    end
  end

  // record monitor
  int stall_left = 0;
  bit recv_burst = 1'b0;

  always @(posedge clk) begin : watch_records
    flvtsa_pkg::record_t got, want;
    string bad;
    logic nr;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        records_rx <= records_rx + 1;
        if (tag_records.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected record: %s", rec_text(got));
        end else begin
          want = tag_records.pop_front();
          status_seen[want.status]++;
          bad = "";
          if (got.status !== want.status) bad = {bad, " status"};
          if (got.tag_kind !== want.tag_kind) bad = {bad, " tag_kind"};
          if (got.body_len !== want.body_len) bad = {bad, " body_len"};
          if (got.timestamp_ms !== want.timestamp_ms) bad = {bad, " timestamp_ms"};
          if (got.codec_or_format !== want.codec_or_format) bad = {bad, " codec_or_format"};
          if (got.is_keyframe !== want.is_keyframe) bad = {bad, " is_keyframe"};
          if (got.sample_rate_hz !== want.sample_rate_hz) bad = {bad, " sample_rate_hz"};
          if (got.sample_is_16bit !== want.sample_is_16bit) bad = {bad, " sample_is_16bit"};
          if (got.is_stereo !== want.is_stereo) bad = {bad, " is_stereo"};
          if (got.video_bytes_total !== want.video_bytes_total) bad = {bad, " video_total"};
          if (got.audio_bytes_total !== want.audio_bytes_total) bad = {bad, " audio_total"};
          if (got.keyframe_total !== want.keyframe_total) bad = {bad, " keyframe_total"};
          if (got.pad !== want.pad) bad = {bad, " pad"};
          if (bad != "") begin
            errors++;
            if (errors <= 10) begin
              $display("record %0d mismatch in%s", records_rx, bad);
              $display("  expected %s", rec_text(want));
              $display("  actual   %s", rec_text(got));
            end
          end
        end
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_tready <= nr;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycles, tag_records.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : run_test
    int r, n_tags, t, cut, k, garbage;
    logic [31:0] hsize, ts_clock, ts;
    logic [23:0] len;
    logic [7:0] ty, fb;

    // broken first signature byte, trailing bytes ignored until end of file
    file_bytes.delete();
    add_header(32'd9);
    file_bytes[0] = 8'h00;
    emit_file(4, 1'b1);
    live_bytes += 1;
    // broken last signature byte that also ends the file
    file_bytes.delete();
    add_header(32'd9);
    file_bytes[3] = 8'hFE;
    emit_file(3, 1'b1);
    live_bytes += 4;
    // file ends inside the signature
    file_bytes.delete();
    add_header(32'd9);
    emit_file(2, 1'b1);
    live_bytes += 3;
    // header size below minimum, no tags at all
    file_bytes.delete();
    add_header(32'd0);
    emit_file(file_bytes.size() - 1, 1'b1);
    live_bytes += file_bytes.size();
    // every tag kind, repairs, discontinuities and stamp extremes
    file_bytes.delete();
    add_header(32'd12);
    add_tag(flvtsa_pkg::TYPE_VIDEO, 24'd5, 32'h00F0_0000, 8'h17);
    add_tag(flvtsa_pkg::TYPE_VIDEO, 24'd1, 32'h0000_0010, 8'h22);
    add_tag(flvtsa_pkg::TYPE_AUDIO, 24'd3, 32'h0000_0020, 8'h4F);
    add_tag(flvtsa_pkg::TYPE_AUDIO, 24'd2, 32'h0200_0000, 8'h5A);
    add_tag(flvtsa_pkg::TYPE_AUDIO, 24'd1, 32'h0200_0000, 8'hFF);
    add_tag(flvtsa_pkg::TYPE_AUDIO, 24'd4, 32'h0200_0000, 8'h00);
    add_tag(flvtsa_pkg::TYPE_AUDIO, 24'd0, 32'h0200_0000, 8'h00);
    add_tag(flvtsa_pkg::TYPE_VIDEO, 24'd0, 32'h0200_0000, 8'h00);
    add_tag(flvtsa_pkg::TYPE_META, 24'd4, 32'h0100_0000, 8'h02);
    add_tag(8'hFF, 24'd2, 32'h0100_0005, 8'hAA);
    add_tag(8'h00, 24'd1, 32'h0200_0000, 8'h55);
    add_tag(flvtsa_pkg::TYPE_VIDEO, 24'd2, 32'hFFFF_FFFF, 8'h1F);
    add_tag(flvtsa_pkg::TYPE_VIDEO, 24'd1, 32'h0000_0001, 8'h31);
    add_tag(flvtsa_pkg::TYPE_VIDEO, 24'd3, 32'h0100_0000, 8'h2C);
    emit_file(file_bytes.size() - 1, 1'b1);
    live_bytes += file_bytes.size();
    // maximum tag length, cut off inside the body
    file_bytes.delete();
    add_header(32'd9);
    add_tag(flvtsa_pkg::TYPE_VIDEO, 24'hFF_FFFF, 32'h1234_5678, 8'h17);
    emit_file(13 + 11 + 4, 1'b1);
    live_bytes += 13 + 11 + 5;
    // maximum header size, cut off in the extra bytes
    file_bytes.delete();
    add_header(32'hFFFF_FFFF);
    emit_file(19, 1'b1);
    live_bytes += 20;
    // end right on a tag boundary, then end on the next type byte
    file_bytes.delete();
    add_header(32'd9);
    add_tag(flvtsa_pkg::TYPE_META, 24'd4, 32'h0000_0100, 8'h02);
    add_tag(8'hA5, 24'd3, 32'h0000_0200, 8'h00);
    emit_file(31, 1'b1);
    emit_file(32, 1'b1);
    live_bytes += 65;

    while (live_bytes < LIVE_BYTES) begin
      file_bytes.delete();
      r = $urandom_range(0, 9);
      if (r < 2) hsize = $urandom_range(0, 8);
      else if (r < 6) hsize = 9;
      else hsize = $urandom_range(10, 24);
      add_header(hsize);
      r = $urandom_range(0, 3);
      ts_clock = (r < 2) ? 32'h0 : ((r == 2) ? $urandom_range(0, 24'hFF_FFFF) : $urandom);
      n_tags = $urandom_range(0, 6);
      for (t = 0; t < n_tags; t++) begin
        r = $urandom_range(0, 9);
        if (r < 4) ty = flvtsa_pkg::TYPE_VIDEO;
        else if (r < 7) ty = flvtsa_pkg::TYPE_AUDIO;
        else if (r == 7) ty = flvtsa_pkg::TYPE_META;
        else ty = 8'($urandom);
        r = $urandom_range(0, 7);
        len = (r == 0) ? 24'd0 : ((r == 1) ? $urandom_range(13, 48) : $urandom_range(1, 12));
        fb = 8'($urandom);
        if (ty == flvtsa_pkg::TYPE_VIDEO && $urandom_range(0, 2) == 0)
          fb[7:4] = flvtsa_pkg::VFRAME_KEY;
        if (ty == flvtsa_pkg::TYPE_AUDIO && $urandom_range(0, 3) == 0)
          fb[7:4] = $urandom_range(0, 1) ? flvtsa_pkg::AFMT_FIXED_16K
                                         : flvtsa_pkg::AFMT_FIXED_8K;
        r = $urandom_range(0, 9);
        if (r <= 6) begin
          ts_clock = ts_clock + $urandom_range(0, 200);
          ts = ts_clock;
        end else if (r == 7) begin
          ts = {8'h00, ts_clock[23:0]};
        end else if (r == 8) begin
          ts = $urandom;
        end else begin
          ts = ts_clock - $urandom_range(1, 300);
        end
        add_tag(ty, len, ts, fb);
      end
      r = $urandom_range(0, 19);
      if (r < 15) begin
        cut = file_bytes.size() - 1;
        live_bytes += cut + 1;
      end else if (r < 18) begin
        cut = $urandom_range(0, file_bytes.size() - 2);
        live_bytes += cut + 1;
      end else begin
        k = $urandom_range(0, 3);
        file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
        garbage = $urandom_range(0, 4);
        cut = k + garbage;
        live_bytes += k + 1;
      end
      emit_file(cut, $urandom_range(0, 15) == 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_tvalid || tag_records.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tag_records.size() != 0) begin
      errors += tag_records.size();
      $display("%0d expected records never arrived", tag_records.size());
    end
    $display("Sent %0d files (%0d parsed bytes), checked %0d records in %0d cycles",
             files_sent, live_bytes, records_rx, cycles);
    $display("  ok %0d, repaired %0d, discontinuity %0d, bad header %0d, truncated %0d",
             status_seen[flvtsa_pkg::ST_OK], status_seen[flvtsa_pkg::ST_FIXED],
             status_seen[flvtsa_pkg::ST_DISCONT], status_seen[flvtsa_pkg::ST_BAD_HDR],
             status_seen[flvtsa_pkg::ST_TRUNC]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
